@@ rtl/rgb_to_hsv_hue_rotated_macros.svh @@
// Assertion macros shared by the rgb_to_hsv_hue_rotated RTL.
`ifndef RGB_TO_HSV_HUE_ROTATED_MACROS_SVH
`define RGB_TO_HSV_HUE_ROTATED_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// cons must hold in any cycle where ante holds
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rhh_pkg.sv @@
// Types and constants shared by the rotated-hue RGB to HSV pipeline.
package rhh_pkg;

  localparam int VAL_W     = 8;   // pixel component / value / saturation / hue width
  localparam int OFFSET_W  = 9;   // hue offset register width
  localparam int SAT_NUM_W = 16;  // 255 * delta
  localparam int HUE_NUM_W = 21;  // 17 * wrapped hue numerator
  localparam int HUE_DEN_W = 13;  // 24 * delta
  localparam int QUOT_W    = 8;   // quotient bits from each divider

  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 9'd40;
  localparam logic [OFFSET_W-1:0] FULL_TURN_DEG = 9'd360;

  // operands handed from the front stages to the dividers
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic                 gray;
    logic [VAL_W-1:0]     value;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_DEN_W-1:0] hue_den;
  } front_out_t;

endpackage

@@ rtl/rhh_front.sv @@
// Front pipeline: max/min, sector, rotation, wrap and divider operand setup.
module rhh_front import rhh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [VAL_W-1:0]    blue_i,
  input  logic [VAL_W-1:0]    green_i,
  input  logic [VAL_W-1:0]    red_i,
  input  logic                last_pixel_i,
  input  logic                hue_offset_we_i,
  input  logic [OFFSET_W-1:0] hue_offset_deg_i,
  output front_out_t          front_o
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // offset register, kept already reduced below a full turn
  logic [OFFSET_W-1:0] off_q, off_d;

  assign off_d = (hue_offset_deg_i >= FULL_TURN_DEG) ? hue_offset_deg_i - FULL_TURN_DEG
                                                     : hue_offset_deg_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= OFFSET_RESET;
    end else if (hue_offset_we_i) begin
      off_q <= off_d;
    end
  end

  // ---------------- stage 1: max, min, sector
  logic             r_ge_g, r_ge_b, g_ge_b;
  sector_e          sec;
  logic [VAL_W-1:0] mx, mn, delta;
  logic signed [VAL_W:0] diff;

  assign r_ge_g = red_i >= green_i;
  assign r_ge_b = red_i >= blue_i;
  assign g_ge_b = green_i >= blue_i;

  always_comb begin
    if (r_ge_g && r_ge_b) begin
      sec  = SEC_RED;
      mx   = red_i;
      diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (g_ge_b) begin
      sec  = SEC_GREEN;
      mx   = green_i;
      diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sec  = SEC_BLUE;
      mx   = blue_i;
      diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_comb begin
    if (!r_ge_g && !r_ge_b) begin
      mn = red_i;
    end else if (r_ge_g && g_ge_b) begin
      mn = blue_i;
    end else if (!g_ge_b && !r_ge_b) begin
      mn = green_i;
    end else if (r_ge_g) begin
      mn = green_i;
    end else begin
      mn = blue_i;
    end
  end

  assign delta = mx - mn;

  logic                  s1_vld_q, s1_last_q;
  logic [VAL_W-1:0]      s1_mx_q, s1_delta_q;
  sector_e               s1_sec_q;
  logic signed [VAL_W:0] s1_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mx_q    <= mx;
    s1_delta_q <= delta;
    s1_sec_q   <= sec;
    s1_diff_q  <= diff;
    s1_last_q  <= last_pixel_i;
  end

  // ---------------- stage 2: sector hue (in units of delta/60), offset * delta
  logic [9:0]           base;
  logic signed [11:0]   t;
  logic [16:0]          prod;
  logic [SAT_NUM_W-1:0] satx;

  always_comb begin
    case (s1_sec_q)
      SEC_RED:   base = '0;
      SEC_GREEN: base = {1'b0, s1_delta_q, 1'b0};
      SEC_BLUE:  base = {s1_delta_q, 2'b00};
      default:   base = '0;
    endcase
  end

  assign t    = $signed({2'b00, base}) + $signed({{3{s1_diff_q[VAL_W]}}, s1_diff_q});
  assign prod = 17'(off_q) * 17'(s1_delta_q);
  assign satx = {s1_delta_q, 8'h00} - {8'h00, s1_delta_q};

  logic                 s2_vld_q, s2_last_q;
  logic [VAL_W-1:0]     s2_mx_q, s2_delta_q;
  logic signed [11:0]   s2_t_q;
  logic [16:0]          s2_prod_q;
  logic [SAT_NUM_W-1:0] s2_satx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mx_q    <= s1_mx_q;
    s2_delta_q <= s1_delta_q;
    s2_t_q     <= t;
    s2_prod_q  <= prod;
    s2_satx_q  <= satx;
    s2_last_q  <= s1_last_q;
  end

  // ---------------- stage 3: numerator = 60*t + off*delta, full turn = 360*delta
  logic signed [18:0] t19, num;
  logic [16:0]        full;

  assign t19  = $signed({{7{s2_t_q[11]}}, s2_t_q});
  assign num  = (t19 <<< 6) - (t19 <<< 2) + $signed({2'b00, s2_prod_q});
  assign full = {1'b0, s2_delta_q, 8'b0} + {3'b0, s2_delta_q, 6'b0}
              + {4'b0, s2_delta_q, 5'b0} + {6'b0, s2_delta_q, 3'b0};

  logic                 s3_vld_q, s3_last_q;
  logic [VAL_W-1:0]     s3_mx_q, s3_delta_q;
  logic signed [18:0]   s3_num_q;
  logic [16:0]          s3_full_q;
  logic [SAT_NUM_W-1:0] s3_satx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_mx_q    <= s2_mx_q;
    s3_delta_q <= s2_delta_q;
    s3_num_q   <= num;
    s3_full_q  <= full;
    s3_satx_q  <= s2_satx_q;
    s3_last_q  <= s2_last_q;
  end

  // ---------------- stage 4: wrap into one full turn
  logic signed [18:0] plus, minus;
  logic               neg, ge;
  logic [16:0]        wrapped;

  assign plus    = s3_num_q + $signed({2'b00, s3_full_q});
  assign minus   = s3_num_q - $signed({2'b00, s3_full_q});
  assign neg     = s3_num_q[18];
  assign ge      = !neg && (s3_num_q[17:0] >= {1'b0, s3_full_q});
  assign wrapped = neg ? plus[16:0] : (ge ? minus[16:0] : s3_num_q[16:0]);

  logic                 s4_vld_q, s4_last_q;
  logic [VAL_W-1:0]     s4_mx_q, s4_delta_q;
  logic [16:0]          s4_h_q;
  logic [SAT_NUM_W-1:0] s4_satx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_mx_q    <= s3_mx_q;
    s4_delta_q <= s3_delta_q;
    s4_h_q     <= wrapped;
    s4_satx_q  <= s3_satx_q;
    s4_last_q  <= s3_last_q;
  end

  // ---------------- stage 5: 255/360 = 17/24, so hue = 17*h / (24*delta)
  logic                 s5_vld_q, s5_last_q, s5_gray_q;
  logic [VAL_W-1:0]     s5_mx_q;
  logic [SAT_NUM_W-1:0] s5_satx_q;
  logic [HUE_NUM_W-1:0] s5_hx_q;
  logic [HUE_DEN_W-1:0] s5_hy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_mx_q   <= s4_mx_q;
    s5_satx_q <= s4_satx_q;
    s5_hx_q   <= {s4_h_q, 4'b0} + {4'b0, s4_h_q};
    s5_hy_q   <= {1'b0, s4_delta_q, 4'b0} + {2'b0, s4_delta_q, 3'b0};
    s5_gray_q <= (s4_delta_q == '0);
    s5_last_q <= s4_last_q;
  end

  assign front_o.vld     = s5_vld_q;
  assign front_o.last    = s5_last_q;
  assign front_o.gray    = s5_gray_q;
  assign front_o.value   = s5_mx_q;
  assign front_o.sat_num = s5_satx_q;
  assign front_o.hue_num = s5_hx_q;
  assign front_o.hue_den = s5_hy_q;

endmodule

@@ rtl/rhh_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rhh_div import rhh_pkg::*; #(
  parameter int DIVIDEND_W = SAT_NUM_W,
  parameter int DIVISOR_W  = VAL_W,
  parameter int QW         = QUOT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  valid_o,
  output logic [QW-1:0]         quot_o
);

  // caller guarantees dividend < divisor * 2**QW
  localparam int CW = (DIVIDEND_W > DIVISOR_W + QW) ? DIVIDEND_W : DIVISOR_W + QW;

  logic                 vld_q [QW];
  logic [QW-1:0]        quo_q [QW];
  logic [CW-1:0]        rem_q [QW-1];
  logic [DIVISOR_W-1:0] den_q [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                 vld_in, take;
    logic [CW-1:0]        rem_in, shifted;
    logic [DIVISOR_W-1:0] den_in;
    logic [QW-1:0]        quo_in;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = CW'(dividend_i);
      assign den_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign shifted = CW'(den_in) << (QW - 1 - s);
    assign take    = rem_in >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= quo_in | (take ? (QW'(1) << (QW - 1 - s)) : '0);
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= take ? rem_in - shifted : rem_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];

endmodule

@@ rtl/rgb_to_hsv_hue_rotated.sv @@
// Top level: RGB pixel in, value, saturation and rotated hue out, one per clock.
//
// Usage:
//   Requests come in on start_i with red_i, green_i, blue_i and last_pixel_i.
//   busy_o is held low, so a request is taken at every clock edge with
//   start_i high: one pixel per clock, back to back without gaps.
//   The result shows on value_o, saturation_o, hue_o and last_out_o once its
//   request has passed every stage, marked by done_o for one cycle.
//   The pipeline is five front stages (max/min, sector, rotate, wrap, operand
//   setup) plus eight stages of each divider, one quotient bit per stage.
//   Results leave in request order; the receiver cannot stall, and none is
//   needed since the pipeline never holds.
//   hue_offset_deg_i is written at any edge with hue_offset_we_i high; write
//   it only while no request is in flight. Values of 360 and up wrap.
//   Reset clears all pipeline valid bits and loads a hue offset of 40 degrees.
`include "rgb_to_hsv_hue_rotated_macros.svh"
module rgb_to_hsv_hue_rotated import rhh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [VAL_W-1:0]    blue_i,
  input  logic [VAL_W-1:0]    green_i,
  input  logic [VAL_W-1:0]    red_i,
  input  logic                last_pixel_i,
  input  logic                hue_offset_we_i,
  input  logic [OFFSET_W-1:0] hue_offset_deg_i,
  output logic                done_o,
  output logic [VAL_W-1:0]    value_o,
  output logic [VAL_W-1:0]    saturation_o,
  output logic [VAL_W-1:0]    hue_o,
  output logic                last_out_o
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             gray;
    logic             last;
  } side_t;

  front_out_t        front;
  side_t             side_q [QUOT_W];
  logic              sat_vld;
  logic [QUOT_W-1:0] sat_quo, hue_quo;

  assign busy_o = 1'b0;

  rhh_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .blue_i,
    .green_i,
    .red_i,
    .last_pixel_i,
    .hue_offset_we_i,
    .hue_offset_deg_i,
    .front_o (front)
  );

  rhh_div #(
    .DIVIDEND_W (SAT_NUM_W),
    .DIVISOR_W  (VAL_W),
    .QW         (QUOT_W)
  ) u_sat_div (
    .clk_i,
    .rst_ni,
    .valid_i    (front.vld),
    .dividend_i (front.sat_num),
    .divisor_i  (front.value),
    .valid_o    (sat_vld),
    .quot_o     (sat_quo)
  );

  rhh_div #(
    .DIVIDEND_W (HUE_NUM_W),
    .DIVISOR_W  (HUE_DEN_W),
    .QW         (QUOT_W)
  ) u_hue_div (
    .clk_i,
    .rst_ni,
    .valid_i    (front.vld),
    .dividend_i (front.hue_num),
    .divisor_i  (front.hue_den),
    .valid_o    (done_o),
    .quot_o     (hue_quo)
  );

  // value, gray flag and frame marker ride alongside the dividers
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{value: front.value, gray: front.gray, last: front.last};
    for (int i = 1; i < QUOT_W; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // gray pixels make the hue divisor zero; force both results to zero
  assign value_o      = side_q[QUOT_W-1].value;
  assign saturation_o = side_q[QUOT_W-1].gray ? '0 : sat_quo;
  assign hue_o        = side_q[QUOT_W-1].gray ? '0 : hue_quo;
  assign last_out_o   = side_q[QUOT_W-1].last;

  `ASSERT_ALWAYS(a_div_lockstep, clk_i, rst_ni, sat_vld == done_o)
  `ASSERT_IMPLIES(a_hue_range, clk_i, rst_ni, done_o, hue_o != 8'hFF)
  `ASSERT_IMPLIES(a_black_is_gray, clk_i, rst_ni, done_o && ~|value_o, {saturation_o, hue_o} == '0)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the rotated-hue RGB to HSV converter.
module tb_top;
  import rhh_pkg::*;

  localparam int PIPE_LAT  = 13;
  localparam int CYCLE_CAP = 400000;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] saturation;
    logic [VAL_W-1:0] hue;
    logic             last;
  } hsv_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [VAL_W-1:0]    blue_i;
  logic [VAL_W-1:0]    green_i;
  logic [VAL_W-1:0]    red_i;
  logic                last_pixel_i;
  logic                hue_offset_we_i;
  logic [OFFSET_W-1:0] hue_offset_deg_i;
  logic                done_o;
  logic [VAL_W-1:0]    value_o;
  logic [VAL_W-1:0]    saturation_o;
  logic [VAL_W-1:0]    hue_o;
  logic                last_out_o;

  hsv_t                expected_hsv[$];
  logic [OFFSET_W-1:0] offset_mirror;
  int                  pixels_accepted;
  int                  err_cnt;
  int                  idle_pct;

  rgb_to_hsv_hue_rotated i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .blue_i           (blue_i),
    .green_i          (green_i),
    .red_i            (red_i),
    .last_pixel_i     (last_pixel_i),
    .hue_offset_we_i  (hue_offset_we_i),
    .hue_offset_deg_i (hue_offset_deg_i),
    .done_o           (done_o),
    .value_o          (value_o),
    .saturation_o     (saturation_o),
    .hue_o            (hue_o),
    .last_out_o       (last_out_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // hue kept as the fraction num / delta in degrees, truncated only at the end
  function automatic hsv_t predict_hsv(logic [VAL_W-1:0] r, logic [VAL_W-1:0] g,
                                       logic [VAL_W-1:0] b, logic last,
                                       logic [OFFSET_W-1:0] offset);
    hsv_t res;
    int   ri, gi, bi, mx, mn, d, num, off;
    ri = r;
    gi = g;
    bi = b;
    mx = (ri > gi) ? ri : gi;
    mx = (mx > bi) ? mx : bi;
    mn = (ri < gi) ? ri : gi;
    mn = (mn < bi) ? mn : bi;
    d  = mx - mn;
    res.value      = VAL_W'(mx);
    res.saturation = '0;
    res.hue        = '0;
    res.last       = last;
    if (d != 0) begin
      res.saturation = VAL_W'((255 * d) / mx);
      if (ri == mx) num = 60 * (gi - bi);
      else if (gi == mx) num = 60 * (2 * d + bi - ri);
      else num = 60 * (4 * d + ri - gi);
      off = offset;
      if (off >= 360) off -= 360;
      num += off * d;
      if (num < 0) num += 360 * d;
      else if (num >= 360 * d) num -= 360 * d;
      res.hue = VAL_W'((num * 255) / (360 * d));
    end
    return res;
  endfunction

  // accepted results checked first, then the request of this edge is predicted
  always @(posedge clk_i) begin
    hsv_t exp_r;
    hsv_t act_r;
    if (!rst_ni) begin
      offset_mirror = OFFSET_RESET;
    end else begin
      if (done_o) begin
        act_r = '{value_o, saturation_o, hue_o, last_out_o};
        if (expected_hsv.size() == 0) begin
          err_cnt++;
          if (err_cnt <= PRINT_CAP)
            $display("%0t: unexpected result v=%0d s=%0d h=%0d l=%0d", $time,
                     act_r.value, act_r.saturation, act_r.hue, act_r.last);
        end else begin
          exp_r = expected_hsv.pop_front();
          if (act_r !== exp_r) begin
            err_cnt++;
            if (err_cnt <= PRINT_CAP)
              $display("%0t: exp v=%0d s=%0d h=%0d l=%0d act v=%0d s=%0d h=%0d l=%0d",
                       $time, exp_r.value, exp_r.saturation, exp_r.hue, exp_r.last,
                       act_r.value, act_r.saturation, act_r.hue, act_r.last);
          end
        end
      end
      if (start_i && !busy_o) begin
        expected_hsv.push_back(predict_hsv(red_i, green_i, blue_i, last_pixel_i,
                                           offset_mirror));
        pixels_accepted++;
      end
      if (hue_offset_we_i) offset_mirror = hue_offset_deg_i;
    end
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called and returns at a falling edge; start stays high for back-to-back requests
  task automatic send_pixel(input logic [VAL_W-1:0] r, input logic [VAL_W-1:0] g,
                            input logic [VAL_W-1:0] b, input logic last);
    int target;
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i      = 1'b1;
    red_i        = r;
    green_i      = g;
    blue_i       = b;
    last_pixel_i = last;
    target       = pixels_accepted + 1;
    do @(negedge clk_i); while (pixels_accepted < target);
  endtask

  task automatic pause_until_drained();
    start_i = 1'b0;
    while (expected_hsv.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT) @(negedge clk_i);
  endtask

  task automatic write_hue_offset(input logic [OFFSET_W-1:0] deg);
    pause_until_drained();
    hue_offset_we_i  = 1'b1;
    hue_offset_deg_i = deg;
    @(negedge clk_i);
    hue_offset_we_i  = 1'b0;
  endtask

  // mix of uniform pixels, grays, two-channel ties and near-gray pixels
  task automatic rand_pixel(output logic [VAL_W-1:0] r, output logic [VAL_W-1:0] g,
                            output logic [VAL_W-1:0] b);
    int sel;
    int base;
    sel = $urandom_range(99);
    r = VAL_W'($urandom_range(255));
    g = VAL_W'($urandom_range(255));
    b = VAL_W'($urandom_range(255));
    if (sel < 8) begin
      g = r;
      b = r;
    end else if (sel < 20) begin
      case ($urandom_range(2))
        0: g = r;
        1: b = g;
        default: r = b;
      endcase
    end else if (sel < 30) begin
      base = $urandom_range(251);
      r = VAL_W'(base + $urandom_range(4));
      g = VAL_W'(base + $urandom_range(4));
      b = VAL_W'(base + $urandom_range(4));
    end
  endtask

  task automatic test_directed_pixels();
    idle_pct = 0;
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);  // black
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // white
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);  // pure primaries
    send_pixel(8'd0,   8'd255, 8'd0,   1'b1);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd10,  1'b0);  // red/green tie
    send_pixel(8'd10,  8'd200, 8'd200, 1'b0);  // green/blue tie
    send_pixel(8'd200, 8'd10,  8'd200, 1'b1);  // red/blue tie
    send_pixel(8'd255, 8'd0,   8'd1,   1'b0);  // negative sector hue
    send_pixel(8'd1,   8'd0,   8'd0,   1'b0);  // smallest delta
    send_pixel(8'd255, 8'd254, 8'd0,   1'b0);
    send_pixel(8'd1,   8'd255, 8'd254, 1'b1);
  endtask

  task automatic test_offset_wrap();
    logic [OFFSET_W-1:0] offs[4];
    offs = '{9'd0, 9'd359, 9'd360, 9'd511};
    idle_pct = 0;
    foreach (offs[i]) begin
      write_hue_offset(offs[i]);
      send_pixel(8'd255, 8'd0,   8'd1,   1'b0);  // just below zero, wraps up at offsets 0 and 360
      send_pixel(8'd255, 8'd1,   8'd255, 1'b0);  // red/blue tie, sector hue of -60 degrees
      send_pixel(8'd77,  8'd77,  8'd77,  1'b1);  // gray ignores the offset
    end
  endtask

  task automatic test_random_stream(input int idle, input logic [OFFSET_W-1:0] deg,
                                    input int count);
    logic [VAL_W-1:0] r, g, b;
    write_hue_offset(deg);
    idle_pct = idle;
    repeat (count) begin
      rand_pixel(r, g, b);
      send_pixel(r, g, b, ($urandom_range(15) == 0));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    red_i            = '0;
    green_i          = '0;
    blue_i           = '0;
    last_pixel_i     = 1'b0;
    hue_offset_we_i  = 1'b0;
    hue_offset_deg_i = '0;
    idle_pct         = 0;
    pixels_accepted  = 0;
    err_cnt          = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_pixels();
    test_offset_wrap();
    test_random_stream(0,  9'd40,  250);
    test_random_stream(88, 9'd0,   200);
    test_random_stream(7,  9'd359, 200);
    test_random_stream(0,  9'd511, 150);
    test_random_stream(88, 9'($urandom_range(511)), 150);
    test_random_stream(7,  9'd180, 150);

    pause_until_drained();
    repeat (PIPE_LAT) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rhh_pkg.sv
rtl/rhh_front.sv
rtl/rhh_div.sv
rtl/rgb_to_hsv_hue_rotated.sv
tb/tb_top.sv
